// ===== src/mlfq_pkg.sv =====
// Package: shared constants, request codes, FSM states and control structs for the scheduler.
`timescale 1ns / 1ps

package mlfq_pkg;

  // Default sizing
  localparam int MAX_TASKS_DEF = 16;
  localparam int LEVELS_DEF    = 16;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int REQ_W   = 2;
  localparam int IDX_FW  = 4;
  localparam int LVL_FW  = 4;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_REPORT   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REP_RD,
    ST_REP_UPD,
    ST_SCAN,
    ST_DRAIN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic ready;          // request channel open
    logic scan_step;      // issue one slot read of the dispatch scan
    logic report_update;  // apply quantum-end report
    logic push;           // hand result to output register
  } cmd_t;

  typedef struct packed {
    logic             in_valid;
    logic [REQ_W-1:0] in_kind;
    logic             scan_last;
    logic             out_free;
  } sts_t;

endpackage

// ===== src/mlfq_req_if.sv =====
// Interface: request channel carrying one scheduler command per transfer.
`timescale 1ns / 1ps

interface mlfq_req_if #(
  parameter int TIME_BITS = mlfq_pkg::TIME_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [mlfq_pkg::REQ_W-1:0]  req_type;
  logic [mlfq_pkg::IDX_FW-1:0] task_index;
  logic [TIME_BITS-1:0]        arrival_time;
  logic [TIME_BITS-1:0]        current_time;
  logic                        task_done;

  modport source (
    output valid, req_type, task_index, arrival_time, current_time, task_done,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_index, arrival_time, current_time, task_done,
    output ready
  );
endinterface

// ===== src/mlfq_rsp_if.sv =====
// Interface: result channel carrying one grant record per transfer.
`timescale 1ns / 1ps

interface mlfq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        grant_valid;
  logic [mlfq_pkg::IDX_FW-1:0] grant_index;
  logic [mlfq_pkg::LVL_FW-1:0] grant_level;
  logic                        first_run;

  modport source (
    output valid, grant_valid, grant_index, grant_level, first_run,
    input  ready
  );
  modport sink (
    input  valid, grant_valid, grant_index, grant_level, first_run,
    output ready
  );
endinterface

// ===== src/mlfq_ctrl.sv =====
// Controller: sequences load, report and dispatch scan operations.
`timescale 1ns / 1ps

module mlfq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mlfq_pkg::sts_t sts_i,
  output mlfq_pkg::cmd_t cmd_o
);

  mlfq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlfq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mlfq_pkg::ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (sts_i.in_valid) begin
          priority if (sts_i.in_kind == mlfq_pkg::REQ_DISPATCH) begin
            state_d = mlfq_pkg::ST_SCAN;
          end else if (sts_i.in_kind == mlfq_pkg::REQ_REPORT) begin
            state_d = mlfq_pkg::ST_REP_RD;
          end else begin
            state_d = mlfq_pkg::ST_PUSH;  // load or unknown code
          end
        end
      end
      mlfq_pkg::ST_REP_RD: begin
        state_d = mlfq_pkg::ST_REP_UPD;
      end
      mlfq_pkg::ST_REP_UPD: begin
        cmd_o.report_update = 1'b1;
        state_d = mlfq_pkg::ST_PUSH;
      end
      mlfq_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = mlfq_pkg::ST_DRAIN;
        end
      end
      mlfq_pkg::ST_DRAIN: begin
        state_d = mlfq_pkg::ST_PUSH;  // last slot compare lands here
      end
      mlfq_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        if (sts_i.out_free) begin
          state_d = mlfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlfq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mlfq_dp.sv =====
// Datapath: task tables, arrival memory, scan compare and output register.
`timescale 1ns / 1ps

module mlfq_dp #(
  parameter int MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF,
  parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int TIME_BITS = mlfq_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mlfq_pkg::CFG_W-1:0] cfg_wdata_i,
  mlfq_req_if.sink                   req,
  mlfq_rsp_if.source                 rsp,
  input  mlfq_pkg::cmd_t             cmd_i,
  output mlfq_pkg::sts_t             sts_o
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int LVL_W = $clog2(LEVELS);

  // configuration
  logic [mlfq_pkg::CFG_W-1:0] active_q;

  // latched request
  logic [mlfq_pkg::REQ_W-1:0]  kind_q;
  logic [mlfq_pkg::IDX_FW-1:0] idx_q;
  logic [TIME_BITS-1:0]        arr_q;
  logic [TIME_BITS-1:0]        now_q;
  logic                        done_q;

  // task state
  logic [TIME_BITS-1:0] arr_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] live_q;
  logic [MAX_TASKS-1:0] started_q;
  logic [LVL_W-1:0]     level_q [MAX_TASKS];
  logic [IDX_W-1:0]     rot_q;

  // scan state
  logic [IDX_W-1:0] scan_addr_q;
  logic [CNT_W-1:0] scan_cnt_q;
  logic             scan_rv_q;
  logic             any_q;
  logic [LVL_W-1:0] best_q;
  logic [IDX_W-1:0] sel_q;
  logic             sel_started_q;

  // registered slot read
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     rd_addr_q;
  logic [TIME_BITS-1:0] rd_arr_q;
  logic                 rd_live_q;
  logic                 rd_started_q;
  logic [LVL_W-1:0]     rd_level_q;

  // output register
  logic                        out_valid_q;
  logic                        out_gv_q;
  logic [mlfq_pkg::IDX_FW-1:0] out_idx_q;
  logic [mlfq_pkg::LVL_FW-1:0] out_lvl_q;
  logic                        out_first_q;

  logic             accept;
  logic             out_free;
  logic             push_fire;
  logic [CNT_W-1:0] slot_n;
  logic [IDX_W-1:0] scan_start;
  logic [CNT_W-1:0] scan_next;
  logic [IDX_W-1:0] slot;
  logic             slot_ok;
  logic [CNT_W-1:0] slot_next;
  logic             is_grant;
  logic             hit;

  assign accept    = cmd_i.ready && req.valid;
  assign out_free  = !out_valid_q || rsp.ready;
  assign push_fire = cmd_i.push && out_free;

  // usable slot count: zero acts as one, clamp at table size
  always_comb begin
    priority if (active_q == '0) begin
      slot_n = CNT_W'(1);
    end else if (32'(active_q) > MAX_TASKS) begin
      slot_n = CNT_W'(MAX_TASKS);
    end else begin
      slot_n = CNT_W'(active_q);
    end
  end

  assign scan_start = (CNT_W'(rot_q) < slot_n) ? rot_q : '0;
  assign scan_next  = CNT_W'(scan_addr_q) + CNT_W'(1);

  assign slot      = IDX_W'(idx_q);
  assign slot_ok   = 32'(idx_q) < MAX_TASKS;
  assign slot_next = CNT_W'(slot) + CNT_W'(1);

  assign rd_addr = cmd_i.scan_step ? scan_addr_q : slot;

  // slot is ready and strictly better than what the scan holds; the strict
  // compare in rotation order keeps the first slot at the lowest level
  assign hit = scan_rv_q && rd_live_q && (rd_arr_q <= now_q) &&
               (!any_q || (rd_level_q < best_q));

  assign is_grant = (kind_q == mlfq_pkg::REQ_DISPATCH) && any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mlfq_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req.req_type;
      idx_q  <= req.task_index;
      arr_q  <= req.arrival_time;
      now_q  <= req.current_time;
      done_q <= req.task_done;
    end
  end

  // arrival memory and slot read
  always_ff @(posedge clk_i) begin
    if (push_fire && (kind_q == mlfq_pkg::REQ_LOAD) && slot_ok) begin
      arr_mem[slot] <= arr_q;
    end
    rd_arr_q     <= arr_mem[rd_addr];
    rd_live_q    <= live_q[rd_addr];
    rd_started_q <= started_q[rd_addr];
    rd_level_q   <= level_q[rd_addr];
    rd_addr_q    <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      started_q <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        level_q[i] <= '0;
      end
      rot_q <= '0;
    end else begin
      if (cmd_i.report_update && slot_ok && rd_live_q) begin
        if (done_q) begin
          live_q[slot] <= 1'b0;
        end else if (32'(rd_level_q) < LEVELS - 1) begin
          level_q[slot] <= rd_level_q + LVL_W'(1);
        end
        rot_q <= (slot_next < slot_n) ? IDX_W'(slot_next) : '0;
      end
      if (push_fire && (kind_q == mlfq_pkg::REQ_LOAD) && slot_ok) begin
        live_q[slot]    <= 1'b1;
        started_q[slot] <= 1'b0;
        level_q[slot]   <= '0;
      end
      if (push_fire && is_grant) begin
        started_q[sel_q] <= 1'b1;
      end
    end
  end

  // dispatch scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      scan_cnt_q  <= '0;
      scan_rv_q   <= 1'b0;
      any_q       <= 1'b0;
    end else begin
      scan_rv_q <= cmd_i.scan_step;
      if (accept) begin
        scan_addr_q <= scan_start;
        scan_cnt_q  <= slot_n - CNT_W'(1);
        any_q       <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_addr_q <= (scan_next < slot_n) ? IDX_W'(scan_next) : '0;
          scan_cnt_q  <= scan_cnt_q - CNT_W'(1);
        end
        if (hit) begin
          any_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      best_q        <= rd_level_q;
      sel_q         <= rd_addr_q;
      sel_started_q <= rd_started_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      out_gv_q    <= is_grant;
      out_idx_q   <= is_grant ? mlfq_pkg::IDX_FW'(sel_q) : '0;
      out_lvl_q   <= is_grant ? mlfq_pkg::LVL_FW'(best_q) : '0;
      out_first_q <= is_grant && !sel_started_q;
    end
  end

  assign req.ready       = cmd_i.ready;
  assign rsp.valid       = out_valid_q;
  assign rsp.grant_valid = out_gv_q;
  assign rsp.grant_index = out_idx_q;
  assign rsp.grant_level = out_lvl_q;
  assign rsp.first_run   = out_first_q;

  assign sts_o.in_valid  = req.valid;
  assign sts_o.in_kind   = req.req_type;
  assign sts_o.scan_last = (scan_cnt_q == '0);
  assign sts_o.out_free  = out_free;

endmodule

// ===== src/multilevel_feedback_task_scheduler.sv =====
// Top level: multilevel feedback queue task scheduler.
`timescale 1ns / 1ps
//
// Usage:
//   req_i carries one command per transfer: load a task into a slot at
//   level 0, ask for a dispatch at current_time, or report a quantum end
//   (task_done retires the task, otherwise it drops one level).
//   rsp_o returns exactly one record per command; only a dispatch that
//   found a ready task sets grant_valid, all other fields are then zero.
//   cfg_we_i/cfg_wdata_i set the active slot count; write it while idle.
// Sequencing (transfer in to result in the output register):
//   a load or unknown code goes straight to the push state, a report
//   reads the slot and then updates it, and a dispatch scans the active
//   slots, one slot per cycle through the registered arrival-memory port,
//   then drains the last compare. Only one command is in flight; a result
//   waiting in the output register does not block the next request from
//   being accepted.
// Stall: if rsp_o.ready is low when a second result is finished, the
//   sequencer holds it until the output register frees up.
// Reset: all slots empty, rotate pointer 0, active count 16. Arrival ticks
//   are not cleared; they are only used for live slots.
//

module multilevel_feedback_task_scheduler #(
  parameter int MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF,
  parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int TIME_BITS = mlfq_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mlfq_pkg::CFG_W-1:0] cfg_wdata_i,
  mlfq_req_if.sink                   req_i,
  mlfq_rsp_if.source                 rsp_o
);

  mlfq_pkg::cmd_t cmd;
  mlfq_pkg::sts_t sts;

  // sequencer
  mlfq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // tables, scan compare, output register
  mlfq_dp #(
    .MAX_TASKS (MAX_TASKS),
    .LEVELS    (LEVELS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
